[hw/rtl/vtf_pkg.sv]
// ---------------------------------------------------------------------------
// vtf_pkg: shared types and constants of the voxel triangle fetch block
// Field widths, status and class codes, face tables and the stage structs.
// ---------------------------------------------------------------------------
`default_nettype none

package vtf_pkg;

  localparam int MAX_DIM      = 64;
  localparam int BITMAP_BYTES = 32768;
  localparam int RAM_AW       = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;

  localparam int CNT_W    = 7;
  localparam int COORD_W  = 6;
  localparam int VOX_W    = 19;
  localparam int IDX_W    = 19;
  localparam int CORNER_W = 19;
  localparam int ADDR_W   = 15;
  localparam int BYTE_W   = 8;
  localparam int TRI_W    = 22;
  localparam int FACE_W   = 3;
  localparam int CXY_W    = 13;
  localparam int N_PROBE  = 5;

  // quotient bits of the coordinate split, three per stage
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = 4;

  // reciprocal of three, exact for 20-bit dividends
  localparam logic [19:0] RECIP_3     = 20'd699051;
  localparam int          RECIP_SHIFT = 21;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] CL_SIDE_EMPTY = 2'd0;
  localparam logic [1:0] CL_WALL       = 2'd1;
  localparam logic [1:0] CL_FLAT       = 2'd2;
  localparam logic [1:0] CL_DIAG       = 2'd3;

  localparam logic [1:0] REG_COUNT_X = 2'd0;
  localparam logic [1:0] REG_COUNT_Y = 2'd1;
  localparam logic [1:0] REG_COUNT_Z = 2'd2;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } off_t;

  // settings derived from the count registers
  typedef struct packed {
    logic [CNT_W-1:0]    cx;
    logic [CNT_W-1:0]    cy;
    logic [CNT_W-1:0]    cz;
    logic [CXY_W-1:0]    cxy;
    logic [VOX_W-1:0]    cxyz;
    logic [CNT_W-1:0]    cx1;
    logic [CXY_W-1:0]    cx1cy1;
  } cfg_t;

  // word travelling down the decode pipeline
  typedef struct packed {
    logic               op;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  val;
    logic [VOX_W-1:0]   rem;
    logic [COORD_W-1:0] zq;
    logic [COORD_W-1:0] yq;
    logic [FACE_W-1:0]  face;
    logic               sub;
    logic               oor;
  } dec_t;

  function automatic off_t mk(input int a, input int b, input int c);
    off_t o;
    o.dx = 2'(a);
    o.dy = 2'(b);
    o.dz = 2'(c);
    return o;
  endfunction

  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // corner offsets of each face, in winding order
  function automatic off_t face_corner(input logic [FACE_W-1:0] f, input logic [1:0] s);
    off_t t [4];
    case (f)
      3'd0: t = '{mk(0,0,0), mk(0,0,1), mk(0,1,1), mk(0,1,0)};
      3'd1: t = '{mk(1,0,0), mk(1,1,0), mk(1,1,1), mk(1,0,1)};
      3'd2: t = '{mk(0,0,0), mk(1,0,0), mk(1,0,1), mk(0,0,1)};
      3'd3: t = '{mk(0,1,0), mk(0,1,1), mk(1,1,1), mk(1,1,0)};
      3'd4: t = '{mk(0,0,0), mk(0,1,0), mk(1,1,0), mk(1,0,0)};
      3'd5: t = '{mk(0,0,1), mk(1,0,1), mk(1,1,1), mk(0,1,1)};
      default: t = '{mk(0,0,0), mk(0,0,0), mk(0,0,0), mk(0,0,0)};
    endcase
    return t[s];
  endfunction

  // outward normal of each face
  function automatic off_t face_normal(input logic [FACE_W-1:0] f);
    off_t n;
    case (f)
      3'd0: n = mk(-1, 0, 0);
      3'd1: n = mk(1, 0, 0);
      3'd2: n = mk(0, -1, 0);
      3'd3: n = mk(0, 1, 0);
      3'd4: n = mk(0, 0, -1);
      3'd5: n = mk(0, 0, 1);
      default: n = mk(0, 0, 0);
    endcase
    return n;
  endfunction

  // direction to the neighbour beside each face edge
  function automatic off_t face_side(input logic [FACE_W-1:0] f, input logic [1:0] e);
    off_t t [4];
    case (f)
      3'd0: t = '{mk(0,-1,0), mk(0,0,1), mk(0,1,0), mk(0,0,-1)};
      3'd1: t = '{mk(0,0,-1), mk(0,1,0), mk(0,0,1), mk(0,-1,0)};
      3'd2: t = '{mk(0,0,-1), mk(1,0,0), mk(0,0,1), mk(-1,0,0)};
      3'd3: t = '{mk(-1,0,0), mk(0,0,1), mk(1,0,0), mk(0,0,-1)};
      3'd4: t = '{mk(-1,0,0), mk(0,1,0), mk(1,0,0), mk(0,-1,0)};
      3'd5: t = '{mk(0,-1,0), mk(1,0,0), mk(0,1,0), mk(-1,0,0)};
      default: t = '{mk(0,0,0), mk(0,0,0), mk(0,0,0), mk(0,0,0)};
    endcase
    return t[e];
  endfunction

  function automatic logic [1:0] edge_cls(input logic side, input logic above);
    logic [1:0] c;
    if (!side) begin
      c = CL_SIDE_EMPTY;
    end else if (above) begin
      c = CL_WALL;
    end else begin
      c = CL_FLAT;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/vtf_ram.sv]
// ---------------------------------------------------------------------------
// vtf_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module vtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/vtf_decode.sv]
// ---------------------------------------------------------------------------
// vtf_decode: triangle number decode pipeline
// Divides by twelve, checks the range and splits the voxel index into x, y, z.
// ---------------------------------------------------------------------------
`default_nettype none

module vtf_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_op,
  input  logic [vtf_pkg::ADDR_W-1:0]   in_addr,
  input  logic [vtf_pkg::BYTE_W-1:0]   in_val,
  input  logic [vtf_pkg::TRI_W-1:0]    in_tri,
  input  vtf_pkg::cfg_t                cfg,
  output logic                         out_valid,
  output vtf_pkg::dec_t                out_dec
);

  import vtf_pkg::*;

  logic              s1_v_r;
  logic              s1_op_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [BYTE_W-1:0] s1_val_r;
  logic [TRI_W-1:0]  s1_tri_r;

  logic [39:0]      prod;
  logic [VOX_W-1:0] q12;
  logic [3:0]       r12;
  dec_t             d2_nxt;
  dec_t             d2_r;
  logic             v2_r;
  dec_t             d3_nxt;

  dec_t d_r   [DIV_STAGES+1];
  logic v_r   [DIV_STAGES+1];
  dec_t d_nxt [DIV_STAGES];

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_op_r   <= in_op;
      s1_addr_r <= in_addr;
      s1_val_r  <= in_val;
      s1_tri_r  <= in_tri;
    end
  end

  // divide by twelve: shift by two then multiply by the reciprocal of three
  assign prod = 40'(s1_tri_r[TRI_W-1:2]) * 40'(RECIP_3);
  assign q12  = prod[RECIP_SHIFT+VOX_W-1:RECIP_SHIFT];
  assign r12  = s1_tri_r[3:0] - {q12[0], 3'b000} - {q12[1:0], 2'b00};

  always_comb begin
    d2_nxt      = '0;
    d2_nxt.op   = s1_op_r;
    d2_nxt.addr = s1_addr_r;
    d2_nxt.val  = s1_val_r;
    d2_nxt.rem  = q12;
    d2_nxt.face = r12[3:1];
    d2_nxt.sub  = s1_tri_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d2_r <= d2_nxt;
  end

  // range check against the voxel count
  always_comb begin
    d3_nxt     = d2_r;
    d3_nxt.oor = (d2_r.rem >= cfg.cxyz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r[0] <= d3_nxt;
  end

  // restoring division: z by cx*cy in two stages, then y by cx in two stages
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    always_comb begin
      dec_t             t;
      logic [VOX_W-1:0] dv;
      logic [VOX_W-1:0] sh;
      logic             qb;
      int               pos;
      t  = d_r[k];
      dv = (k < 2) ? VOX_W'(cfg.cxy) : VOX_W'(cfg.cx);
      for (int j = 0; j < DIV_BITS; j++) begin
        pos = DIV_BITS * ((k + 1) % 2) + (DIV_BITS - 1 - j);
        sh  = dv << pos;
        qb  = (t.rem >= sh);
        if (qb) begin
          t.rem = t.rem - sh;
        end
        if (k < 2) begin
          t.zq[pos] = qb;
        end else begin
          t.yq[pos] = qb;
        end
      end
      d_nxt[k] = t;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      d_r[k+1] <= d_nxt[k];
    end
  end

  assign out_valid = v_r[DIV_STAGES];
  assign out_dec   = d_r[DIV_STAGES];

endmodule

`default_nettype wire

[hw/rtl/vtf_lookup.sv]
// ---------------------------------------------------------------------------
// vtf_lookup: bitmap probes, corner indices and edge classes
// Forms five probe addresses, reads the bitmap copies and builds the result.
// ---------------------------------------------------------------------------
`default_nettype none

module vtf_lookup (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  vtf_pkg::dec_t                  in_dec,
  input  vtf_pkg::cfg_t                  cfg,
  output logic                           out_strobe,
  output logic [1:0]                     out_status,
  output logic [vtf_pkg::COORD_W-1:0]    out_voxel_x,
  output logic [vtf_pkg::COORD_W-1:0]    out_voxel_y,
  output logic [vtf_pkg::COORD_W-1:0]    out_voxel_z,
  output logic [vtf_pkg::FACE_W-1:0]     out_face,
  output logic [vtf_pkg::CORNER_W-1:0]   out_corner_first,
  output logic [vtf_pkg::CORNER_W-1:0]   out_corner_second,
  output logic [vtf_pkg::CORNER_W-1:0]   out_corner_third,
  output logic [1:0]                     out_edge_one_class,
  output logic [1:0]                     out_edge_two_class,
  output logic [1:0]                     out_edge_three_class
);

  import vtf_pkg::*;

  logic [COORD_W-1:0] vx;
  logic [COORD_W-1:0] vy;
  logic [COORD_W-1:0] vz;
  off_t               p_off [N_PROBE];
  logic [RAM_AW-1:0]  p_byte [N_PROBE];
  logic [2:0]         p_bit [N_PROBE];
  logic               p_hit [N_PROBE];
  logic [CORNER_W-1:0] c_val [3];

  // probe stage registers
  logic               a_v_r;
  dec_t               a_dec_r;
  logic [RAM_AW-1:0]  a_byte_r [N_PROBE];
  logic [2:0]         a_bit_r [N_PROBE];
  logic               a_hit_r [N_PROBE];
  logic [CORNER_W-1:0] a_c_r [3];
  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_q [N_PROBE];

  // read data stage registers
  logic               b_v_r;
  dec_t               b_dec_r;
  logic [2:0]         b_bit_r [N_PROBE];
  logic               b_hit_r [N_PROBE];
  logic [CORNER_W-1:0] b_c_r [3];
  logic               solid [N_PROBE];

  // result registers
  logic                c_v_r;
  logic [1:0]          st_nxt, st_r;
  logic [COORD_W-1:0]  x_nxt, x_r, y_nxt, y_r, z_nxt, z_r;
  logic [FACE_W-1:0]   f_nxt, f_r;
  logic [CORNER_W-1:0] k1_nxt, k1_r, k2_nxt, k2_r, k3_nxt, k3_r;
  logic [1:0]          e1_nxt, e1_r, e2_nxt, e2_r, e3_nxt, e3_r;

  assign vx = in_dec.rem[COORD_W-1:0];
  assign vy = in_dec.yq;
  assign vz = in_dec.zq;

  // probe offsets: centre, then side and side-above for both side edges
  always_comb begin
    off_t n;
    off_t sa;
    off_t sb;
    n  = face_normal(in_dec.face);
    sa = face_side(in_dec.face, {in_dec.sub, 1'b0});
    sb = face_side(in_dec.face, {in_dec.sub, 1'b1});
    p_off[0] = mk(0, 0, 0);
    p_off[1] = sa;
    p_off[2] = mk(int'(sa.dx) + int'(n.dx), int'(sa.dy) + int'(n.dy),
                  int'(sa.dz) + int'(n.dz));
    p_off[3] = sb;
    p_off[4] = mk(int'(sb.dx) + int'(n.dx), int'(sb.dy) + int'(n.dy),
                  int'(sb.dz) + int'(n.dz));
  end

  // probe addresses and bounds
  for (genvar p = 0; p < N_PROBE; p++) begin : g_probe
    always_comb begin
      logic signed [7:0] px;
      logic signed [7:0] py;
      logic signed [7:0] pz;
      logic              inb;
      logic [IDX_W-1:0]  idx;
      px  = $signed({2'b00, vx}) + 8'(p_off[p].dx);
      py  = $signed({2'b00, vy}) + 8'(p_off[p].dy);
      pz  = $signed({2'b00, vz}) + 8'(p_off[p].dz);
      inb = !px[7] && !py[7] && !pz[7] &&
            (px[6:0] < cfg.cx) && (py[6:0] < cfg.cy) && (pz[6:0] < cfg.cz);
      idx = IDX_W'(px[COORD_W-1:0])
          + IDX_W'(cfg.cx) * IDX_W'(py[COORD_W-1:0])
          + IDX_W'(cfg.cxy) * IDX_W'(pz[COORD_W-1:0]);
      p_byte[p] = RAM_AW'(idx >> 3);
      p_bit[p]  = idx[2:0];
      p_hit[p]  = inb && (32'(idx >> 3) < BITMAP_BYTES);
    end
  end

  // grid corner indices
  for (genvar i = 0; i < 3; i++) begin : g_corner
    always_comb begin
      logic [1:0]       sel;
      off_t             o;
      logic [CNT_W-1:0] cx7;
      logic [CNT_W-1:0] cy7;
      logic [CNT_W-1:0] cz7;
      sel = (i == 0) ? 2'd0 : (2'(i) + {1'b0, in_dec.sub});
      o   = face_corner(in_dec.face, sel);
      cx7 = CNT_W'(vx) + CNT_W'(o.dx[0]);
      cy7 = CNT_W'(vy) + CNT_W'(o.dy[0]);
      cz7 = CNT_W'(vz) + CNT_W'(o.dz[0]);
      c_val[i] = CORNER_W'(cx7)
               + CORNER_W'(cfg.cx1) * CORNER_W'(cy7)
               + CORNER_W'(cfg.cx1cy1) * CORNER_W'(cz7);
    end
  end

  // probe stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_dec_r  <= in_dec;
    a_byte_r <= p_byte;
    a_bit_r  <= p_bit;
    a_hit_r  <= p_hit;
    a_c_r    <= c_val;
  end

  // one bitmap copy per probe, every load writes all of them
  assign ram_we = a_v_r && (a_dec_r.op == OP_LOAD) && (32'(a_dec_r.addr) < BITMAP_BYTES);
  assign ram_re = a_v_r && (a_dec_r.op == OP_FETCH);

  for (genvar p = 0; p < N_PROBE; p++) begin : g_ram
    vtf_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(BITMAP_BYTES)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (RAM_AW'(a_dec_r.addr)),
      .wdata (a_dec_r.val),
      .re    (ram_re),
      .raddr (a_byte_r[p]),
      .rdata (ram_q[p])
    );
  end

  // read data stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_dec_r <= a_dec_r;
    b_bit_r <= a_bit_r;
    b_hit_r <= a_hit_r;
    b_c_r   <= a_c_r;
  end

  for (genvar p = 0; p < N_PROBE; p++) begin : g_solid
    assign solid[p] = b_hit_r[p] && ram_q[p][b_bit_r[p]];
  end

  // result word
  always_comb begin
    st_nxt = ST_OK;
    x_nxt  = '0;
    y_nxt  = '0;
    z_nxt  = '0;
    f_nxt  = '0;
    k1_nxt = '0;
    k2_nxt = '0;
    k3_nxt = '0;
    e1_nxt = CL_SIDE_EMPTY;
    e2_nxt = CL_SIDE_EMPTY;
    e3_nxt = CL_SIDE_EMPTY;
    if (b_dec_r.op == OP_FETCH) begin
      if (b_dec_r.oor) begin
        st_nxt = ST_RANGE;
      end else begin
        x_nxt = b_dec_r.rem[COORD_W-1:0];
        y_nxt = b_dec_r.yq;
        z_nxt = b_dec_r.zq;
        f_nxt = b_dec_r.face;
        if (!solid[0]) begin
          st_nxt = ST_EMPTY;
        end else begin
          k1_nxt = b_c_r[0];
          k2_nxt = b_c_r[1];
          k3_nxt = b_c_r[2];
          if (!b_dec_r.sub) begin
            e1_nxt = edge_cls(solid[1], solid[2]);
            e2_nxt = edge_cls(solid[3], solid[4]);
            e3_nxt = CL_DIAG;
          end else begin
            e1_nxt = CL_DIAG;
            e2_nxt = edge_cls(solid[1], solid[2]);
            e3_nxt = edge_cls(solid[3], solid[4]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    f_r  <= f_nxt;
    k1_r <= k1_nxt;
    k2_r <= k2_nxt;
    k3_r <= k3_nxt;
    e1_r <= e1_nxt;
    e2_r <= e2_nxt;
    e3_r <= e3_nxt;
  end

  assign out_strobe           = c_v_r;
  assign out_status           = st_r;
  assign out_voxel_x          = x_r;
  assign out_voxel_y          = y_r;
  assign out_voxel_z          = z_r;
  assign out_face             = f_r;
  assign out_corner_first     = k1_r;
  assign out_corner_second    = k2_r;
  assign out_corner_third     = k3_r;
  assign out_edge_one_class   = e1_r;
  assign out_edge_two_class   = e2_r;
  assign out_edge_three_class = e3_r;

endmodule

`default_nettype wire

[hw/rtl/voxel_triangle_fetch.sv]
// ---------------------------------------------------------------------------
// voxel_triangle_fetch: voxel bitmap store and triangle geometry fetch
// Loads occupancy bytes and decodes triangle numbers into corners and classes.
// ---------------------------------------------------------------------------
// Usage
//   A word is taken on every rising edge with start high; busy stays low, so
//   one word may follow another in every cycle.
//   op load writes one bitmap byte; op fetch decodes a triangle number into
//   voxel x, y, z, face, a grid corner index per triangle corner and a class per edge.
//   Every word gives exactly one result, in order, shown for one cycle with
//   out_strobe, driven by the result stage. Throughput is one word per
//   cycle: the pipeline has ten register stages (input, divide by twelve,
//   range check, four division stages, probe address, bitmap read, result)
//   and the five bitmap reads of a fetch go to five copies of the bitmap.
//   The receiver cannot stall, so nothing in the pipeline ever waits.
//   Count registers are written on cfg_we and should only change while no
//   word is in flight. Reset sets all counts to 1 and empties the pipeline;
//   the bitmap is not cleared and a byte must be loaded before it is read.
// ---------------------------------------------------------------------------
`default_nettype none

module voxel_triangle_fetch (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [vtf_pkg::ADDR_W-1:0]     in_byte_address,
  input  logic [vtf_pkg::BYTE_W-1:0]     in_byte_value,
  input  logic [vtf_pkg::TRI_W-1:0]      in_triangle_index,
  output logic                           out_strobe,
  output logic [1:0]                     out_status,
  output logic [vtf_pkg::COORD_W-1:0]    out_voxel_x,
  output logic [vtf_pkg::COORD_W-1:0]    out_voxel_y,
  output logic [vtf_pkg::COORD_W-1:0]    out_voxel_z,
  output logic [vtf_pkg::FACE_W-1:0]     out_face,
  output logic [vtf_pkg::CORNER_W-1:0]   out_corner_first,
  output logic [vtf_pkg::CORNER_W-1:0]   out_corner_second,
  output logic [vtf_pkg::CORNER_W-1:0]   out_corner_third,
  output logic [1:0]                     out_edge_one_class,
  output logic [1:0]                     out_edge_two_class,
  output logic [1:0]                     out_edge_three_class,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [vtf_pkg::CNT_W-1:0]      cfg_wdata
);

  import vtf_pkg::*;

  logic [CNT_W-1:0] count_x_r;
  logic [CNT_W-1:0] count_y_r;
  logic [CNT_W-1:0] count_z_r;
  logic [CNT_W-1:0] eff_x;
  logic [CNT_W-1:0] eff_y;
  logic [CNT_W-1:0] eff_z;
  logic [CXY_W-1:0] cxy_r;
  logic [VOX_W-1:0] cxyz_r;
  logic [CXY_W-1:0] cx1cy1_r;
  cfg_t             cfg;
  logic             in_valid;
  logic             dec_valid;
  dec_t             dec_word;

  // count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_x_r <= CNT_W'(1);
      count_y_r <= CNT_W'(1);
      count_z_r <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT_X: count_x_r <= cfg_wdata;
        REG_COUNT_Y: count_y_r <= cfg_wdata;
        REG_COUNT_Z: count_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_x = sat_count(count_x_r);
  assign eff_y = sat_count(count_y_r);
  assign eff_z = sat_count(count_z_r);

  // products of the counts, settled well before a word needs them
  always_ff @(posedge clk) begin
    cxy_r    <= CXY_W'(eff_x) * CXY_W'(eff_y);
    cxyz_r   <= VOX_W'(cxy_r) * VOX_W'(eff_z);
    cx1cy1_r <= CXY_W'(eff_x + CNT_W'(1)) * CXY_W'(eff_y + CNT_W'(1));
  end

  always_comb begin
    cfg.cx     = eff_x;
    cfg.cy     = eff_y;
    cfg.cz     = eff_z;
    cfg.cxy    = cxy_r;
    cfg.cxyz   = cxyz_r;
    cfg.cx1    = eff_x + CNT_W'(1);
    cfg.cx1cy1 = cx1cy1_r;
  end

  // the pipeline never holds back a word
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  vtf_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_addr   (in_byte_address),
    .in_val    (in_byte_value),
    .in_tri    (in_triangle_index),
    .cfg       (cfg),
    .out_valid (dec_valid),
    .out_dec   (dec_word)
  );

  vtf_lookup u_lookup (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (dec_valid),
    .in_dec               (dec_word),
    .cfg                  (cfg),
    .out_strobe           (out_strobe),
    .out_status           (out_status),
    .out_voxel_x          (out_voxel_x),
    .out_voxel_y          (out_voxel_y),
    .out_voxel_z          (out_voxel_z),
    .out_face             (out_face),
    .out_corner_first     (out_corner_first),
    .out_corner_second    (out_corner_second),
    .out_corner_third     (out_corner_third),
    .out_edge_one_class   (out_edge_one_class),
    .out_edge_two_class   (out_edge_two_class),
    .out_edge_three_class (out_edge_three_class)
  );

  // every accepted word comes out with a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##10 out_strobe)
    else $error("result strobe missing ten cycles after accept");

  // no result strobe without an earlier accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    ##10 out_strobe |-> $past(start && !busy, 10))
    else $error("result strobe without an accepted word");

  // an empty or out-of-range result carries no corners and no classes
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_EMPTY || out_status == ST_RANGE)) |->
      (out_corner_first == '0 && out_corner_second == '0 &&
       out_corner_third == '0 && out_edge_one_class == CL_SIDE_EMPTY &&
       out_edge_two_class == CL_SIDE_EMPTY && out_edge_three_class == CL_SIDE_EMPTY))
    else $error("flagged result carries geometry");

  // a good fetch with a diagonal first or last edge has no diagonal middle edge
  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_OK && out_face <= 3'd5 &&
     (out_edge_one_class == CL_DIAG || out_edge_three_class == CL_DIAG)) |->
      (out_edge_two_class != CL_DIAG))
    else $error("edge classes out of order");

endmodule

`default_nettype wire

[bench/voxel_triangle_fetch_tb.sv]
// ---------------------------------------------------------------------------
// voxel_triangle_fetch_tb: self-checking bench for the voxel triangle fetch
// Drives bitmap loads and triangle fetches under several count settings,
// predicts every result from a local bitmap copy and checks it in order.
// ---------------------------------------------------------------------------
`default_nettype none

module voxel_triangle_fetch_tb;
  import vtf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               op;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  val;
    logic [TRI_W-1:0]   tri_n;
  } word_t;

  typedef struct {
    int status, vx, vy, vz, face, c1, c2, c3, e1, e2, e3;
  } tri_res_t;

  // face geometry: corners, normals and side directions
  localparam int FC [6][12] = '{
    '{0,0,0, 0,0,1, 0,1,1, 0,1,0}, '{1,0,0, 1,1,0, 1,1,1, 1,0,1},
    '{0,0,0, 1,0,0, 1,0,1, 0,0,1}, '{0,1,0, 0,1,1, 1,1,1, 1,1,0},
    '{0,0,0, 0,1,0, 1,1,0, 1,0,0}, '{0,0,1, 1,0,1, 1,1,1, 0,1,1}};
  localparam int FN [6][3] = '{
    '{-1,0,0}, '{1,0,0}, '{0,-1,0}, '{0,1,0}, '{0,0,-1}, '{0,0,1}};
  localparam int FS [6][12] = '{
    '{0,-1,0, 0,0,1, 0,1,0, 0,0,-1}, '{0,0,-1, 0,1,0, 0,0,1, 0,-1,0},
    '{0,0,-1, 1,0,0, 0,0,1, -1,0,0}, '{-1,0,0, 0,0,1, 1,0,0, 0,0,-1},
    '{-1,0,0, 0,1,0, 1,0,0, 0,-1,0}, '{0,-1,0, 1,0,0, 0,1,0, -1,0,0}};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_op = 1'b0;
  logic [ADDR_W-1:0]   in_byte_address = '0;
  logic [BYTE_W-1:0]   in_byte_value = '0;
  logic [TRI_W-1:0]    in_triangle_index = '0;
  logic                out_strobe;
  logic [1:0]          out_status;
  logic [COORD_W-1:0]  out_voxel_x, out_voxel_y, out_voxel_z;
  logic [FACE_W-1:0]   out_face;
  logic [CORNER_W-1:0] out_corner_first, out_corner_second, out_corner_third;
  logic [1:0]          out_edge_one_class, out_edge_two_class, out_edge_three_class;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [CNT_W-1:0]    cfg_wdata = '0;

  word_t    pending_words [$];
  tri_res_t expected_results [$];
  logic [7:0] occ_copy [BITMAP_BYTES];
  bit       byte_loaded [BITMAP_BYTES];
  int       cnt_reg [3] = '{1, 1, 1};
  int       idle_pct = 0;
  int       fails = 0;
  logic     took = 1'b0;

  voxel_triangle_fetch u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_byte_address(in_byte_address), .in_byte_value(in_byte_value),
    .in_triangle_index(in_triangle_index),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_voxel_x(out_voxel_x), .out_voxel_y(out_voxel_y), .out_voxel_z(out_voxel_z),
    .out_face(out_face), .out_corner_first(out_corner_first),
    .out_corner_second(out_corner_second), .out_corner_third(out_corner_third),
    .out_edge_one_class(out_edge_one_class), .out_edge_two_class(out_edge_two_class),
    .out_edge_three_class(out_edge_three_class),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int eff(input int v);
    int r;
    r = (v < 1) ? 1 : (v > MAX_DIM) ? MAX_DIM : v;
    return r;
  endfunction

  function automatic bit solid(input int x, input int y, input int z);
    int cx, cy, cz, idx;
    cx = eff(cnt_reg[0]);
    cy = eff(cnt_reg[1]);
    cz = eff(cnt_reg[2]);
    if (x < 0 || y < 0 || z < 0 || x >= cx || y >= cy || z >= cz) return 1'b0;
    idx = x + cx * (y + cy * z);
    if ((idx >> 3) >= BITMAP_BYTES) return 1'b0;
    return occ_copy[idx >> 3][idx & 7];
  endfunction

  function automatic int side_class(input int x, input int y, input int z,
                                    input int f, input int e);
    int dx, dy, dz;
    dx = x + FS[f][3*e];
    dy = y + FS[f][3*e+1];
    dz = z + FS[f][3*e+2];
    if (!solid(dx, dy, dz)) return CL_SIDE_EMPTY;
    if (solid(dx + FN[f][0], dy + FN[f][1], dz + FN[f][2])) return CL_WALL;
    return CL_FLAT;
  endfunction

  // expected result of one word; loads update the bitmap copy
  function automatic tri_res_t fetch_geometry(input word_t w);
    tri_res_t r;
    int cx, cy, cz, vox, sub, sel, i, c;
    r = '{default: 0};
    cx = eff(cnt_reg[0]);
    cy = eff(cnt_reg[1]);
    cz = eff(cnt_reg[2]);
    if (w.op == OP_LOAD) begin
      occ_copy[w.addr] = w.val;
      return r;
    end
    if (int'(w.tri_n) >= 12 * cx * cy * cz) begin
      r.status = ST_RANGE;
      return r;
    end
    vox = int'(w.tri_n) / 12;
    r.face = (int'(w.tri_n) % 12) / 2;
    sub = int'(w.tri_n) & 1;
    r.vx = vox % cx;
    r.vy = (vox / cx) % cy;
    r.vz = vox / (cx * cy);
    if (!solid(r.vx, r.vy, r.vz)) begin
      r.status = ST_EMPTY;
      return r;
    end
    for (i = 0; i < 3; i++) begin
      sel = (i == 0) ? 0 : i + sub;
      c = (r.vx + FC[r.face][3*sel]) + (cx + 1) * ((r.vy + FC[r.face][3*sel+1])
          + (cy + 1) * (r.vz + FC[r.face][3*sel+2]));
      c = c & 32'h7FFFF;
      if (i == 0) r.c1 = c; else if (i == 1) r.c2 = c; else r.c3 = c;
    end
    if (sub == 0) begin
      r.e1 = side_class(r.vx, r.vy, r.vz, r.face, 0);
      r.e2 = side_class(r.vx, r.vy, r.vz, r.face, 1);
      r.e3 = CL_DIAG;
    end else begin
      r.e1 = CL_DIAG;
      r.e2 = side_class(r.vx, r.vy, r.vz, r.face, 2);
      r.e3 = side_class(r.vx, r.vy, r.vz, r.face, 3);
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endfunction

  // driver: next word at the falling edge
  always @(negedge clk) begin
    logic go;
    if (rst_n) begin
      if (start && took) void'(pending_words.pop_front());
      go = (start && !took) ||
           (pending_words.size() > 0 && $urandom_range(99) >= idle_pct);
      if (go) begin
        in_op             <= pending_words[0].op;
        in_byte_address   <= pending_words[0].addr;
        in_byte_value     <= pending_words[0].val;
        in_triangle_index <= pending_words[0].tri_n;
      end
      start <= go;
    end
  end

  // monitor: accept words and check results at the rising edge
  always @(posedge clk) begin
    tri_res_t e;
    word_t w;
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual status %0d",
                   $time, out_status);
          fails++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, int'(out_status));
          check_field("voxel_x", e.vx, int'(out_voxel_x));
          check_field("voxel_y", e.vy, int'(out_voxel_y));
          check_field("voxel_z", e.vz, int'(out_voxel_z));
          check_field("face", e.face, int'(out_face));
          check_field("corner_first", e.c1, int'(out_corner_first));
          check_field("corner_second", e.c2, int'(out_corner_second));
          check_field("corner_third", e.c3, int'(out_corner_third));
          check_field("edge_one_class", e.e1, int'(out_edge_one_class));
          check_field("edge_two_class", e.e2, int'(out_edge_two_class));
          check_field("edge_three_class", e.e3, int'(out_edge_three_class));
        end
      end
      if (start && !busy) begin
        w.op = in_op;
        w.addr = in_byte_address;
        w.val = in_byte_value;
        w.tri_n = in_triangle_index;
        expected_results.push_back(fetch_geometry(w));
      end
      took <= start && !busy;
    end
  end

  task automatic push_load(input int a, input int v);
    word_t w;
    w.op = OP_LOAD;
    w.addr = ADDR_W'(a);
    w.val = BYTE_W'(v);
    w.tri_n = TRI_W'($urandom_range(22'h3FFFFF));
    byte_loaded[a] = 1'b1;
    pending_words.push_back(w);
  endtask

  // fetch word; for an in-range number, each byte around the voxel not yet loaded is loaded first
  task automatic push_fetch(input int n);
    word_t w;
    int cx, cy, cz, vox, x, y, z, dx, dy, dz, b;
    cx = eff(cnt_reg[0]);
    cy = eff(cnt_reg[1]);
    cz = eff(cnt_reg[2]);
    if (n < 12 * cx * cy * cz) begin
      vox = n / 12;
      x = vox % cx;
      y = (vox / cx) % cy;
      z = vox / (cx * cy);
      for (dz = -1; dz <= 1; dz++)
        for (dy = -1; dy <= 1; dy++)
          for (dx = -1; dx <= 1; dx++)
            if (x+dx >= 0 && y+dy >= 0 && z+dz >= 0 && x+dx < cx && y+dy < cy
                && z+dz < cz) begin
              b = ((x+dx) + cx * ((y+dy) + cy * (z+dz))) >> 3;
              if (!byte_loaded[b]) push_load(b, $urandom_range(255));
            end
    end
    w.op = OP_FETCH;
    w.addr = ADDR_W'($urandom_range(32767));
    w.val = BYTE_W'($urandom_range(255));
    w.tri_n = TRI_W'(n);
    pending_words.push_back(w);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_results.size() > 0 || start)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_counts(input int cx, input int cy, input int cz);
    int vals [3];
    int i;
    vals = '{cx, cy, cz};
    for (i = 0; i < 3; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= (i == 0) ? REG_COUNT_X : (i == 1) ? REG_COUNT_Y : REG_COUNT_Z;
      cfg_wdata <= CNT_W'(vals[i]);
      cnt_reg[i] = vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_coord(input int c);
    int r, span;
    r = $urandom_range(9);
    span = (c > 4) ? 3 : c - 1;
    if (r == 0) return $urandom_range(c - 1);
    if (r < 5) return $urandom_range(span);
    return c - 1 - $urandom_range(span);
  endfunction

  // random words: loads, out-of-range and mostly in-range fetches
  task automatic random_words(input int count);
    int cx, cy, cz, total, start_len, r, vox;
    cx = eff(cnt_reg[0]);
    cy = eff(cnt_reg[1]);
    cz = eff(cnt_reg[2]);
    total = 12 * cx * cy * cz;
    start_len = pending_words.size();
    while (pending_words.size() - start_len < count) begin
      r = $urandom_range(99);
      if (r < 20) begin
        push_load($urandom_range(32767), $urandom_range(255));
      end else if (r < 30 && total <= 22'h3FFFFF) begin
        push_fetch($urandom_range(22'h3FFFFF, total));
      end else begin
        vox = pick_coord(cx) + cx * (pick_coord(cy) + cy * pick_coord(cz));
        push_fetch(12 * vox + $urandom_range(11));
      end
    end
  endtask

  // stimulus
  initial begin
    int i;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: small field, every face and sub, range edges, empty voxel
    write_counts(2, 3, 2);
    push_load(32767, 255);
    push_load(0, 255);
    for (i = 0; i < 12; i++) push_fetch(i);
    push_fetch(12 * 12 - 1);
    push_fetch(12 * 12);
    push_fetch(22'h3FFFFF);
    push_load(0, 0);
    push_fetch(5);
    push_load(0, 8'hA5);
    push_fetch(12 * 5 + 7);
    drain();

    // largest field, sender idle about half the time, one full pause midway
    write_counts(64, 64, 64);
    idle_pct = 48;
    push_fetch(0);
    push_fetch(3145727);
    random_words(250);
    while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk);
    random_words(250);
    drain();

    // saturated counts
    write_counts(0, 127, 3);
    idle_pct = 20;
    random_words(350);
    drain();

    // single voxel, no idling
    write_counts(1, 1, 1);
    idle_pct = 0;
    random_words(200);
    drain();

    // uneven field
    write_counts(37, 5, 64);
    idle_pct = 48;
    random_words(400);
    drain();

    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hw/rtl/vtf_pkg.sv
hw/rtl/vtf_ram.sv
hw/rtl/vtf_decode.sv
hw/rtl/vtf_lookup.sv
hw/rtl/voxel_triangle_fetch.sv
bench/voxel_triangle_fetch_tb.sv
